/* rtl/core/kvi_pkg.sv */
// Package for the keyframe vector interpolator: constants and shared types.
package kvi_pkg;

  localparam int MAX_KEYS_DEF = 64;
  localparam int CNT_W        = 7;
  localparam int SLOT_W       = 6;
  localparam int VAL_W        = 32;
  localparam int FAC_W        = 17;
  localparam int ONE_FACTOR   = 65536;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // One key as held by a cell.
  typedef struct packed {
    logic [VAL_W-1:0] t;
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] z;
  } key_t;

  // Load request broadcast along the chain.
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    key_t              key;
  } load_t;

endpackage

/* rtl/core/kvi_cell.sv */
// One key cell: holds a key and passes its neighbor's key down the rotate chain.
module kvi_cell #(
  parameter int IDX_W = 6,
  parameter int MY_IDX = 0
) (
  input  logic        clk,
  input  logic        load_we,
  input  logic [IDX_W-1:0] load_idx,
  input  kvi_pkg::key_t    load_key,
  input  logic        shift_en,
  input  logic        rot_sel,
  input  kvi_pkg::key_t    next_key,
  output kvi_pkg::key_t    key_q
);

  kvi_pkg::key_t key_r;
  kvi_pkg::key_t key_nxt;

  always_comb begin
    key_nxt = key_r;
    if (load_we && (load_idx == IDX_W'(MY_IDX))) begin
      key_nxt = load_key;
    end else if (shift_en && rot_sel) begin
      key_nxt = next_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key_q = key_r;

endmodule

/* rtl/core/kvi_div.sv */
// Restoring divider producing a 17-bit quotient of (num << 16) / den, one bit a cycle.
module kvi_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [kvi_pkg::VAL_W-1:0] num,
  input  logic [kvi_pkg::VAL_W-1:0] den,
  output logic                      done,
  output logic [kvi_pkg::FAC_W-1:0] quo
);

  localparam int RW = kvi_pkg::VAL_W + 1;
  localparam int STEPS = 48;
  localparam int SW = $clog2(STEPS + 1);

  logic [RW-1:0]  rem_r, rem_nxt;
  logic [47:0]    dvd_r, dvd_nxt;
  logic [kvi_pkg::FAC_W-1:0] quo_r, quo_nxt;
  logic [SW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [RW-1:0]  trial;

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[RW-2:0], dvd_r[47]};
    if (start) begin
      rem_nxt  = '0;
      dvd_nxt  = {num, 16'd0};
      quo_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[46:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem_nxt = trial - {1'b0, den};
        quo_nxt = {quo_r[kvi_pkg::FAC_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[kvi_pkg::FAC_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + SW'(1);
      if (cnt_r == SW'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* rtl/core/kvi_lerp.sv */
// One lerp component: start + round(delta * factor / 65536), product registered.
module kvi_lerp (
  input  logic                      clk,
  input  logic [kvi_pkg::VAL_W-1:0] s_val,
  input  logic [kvi_pkg::VAL_W-1:0] e_val,
  input  logic [kvi_pkg::FAC_W-1:0] factor,
  output logic [kvi_pkg::VAL_W-1:0] res
);

  logic signed [32:0] delta;
  logic signed [50:0] prod_r;
  logic signed [50:0] rnd;

  assign delta = 33'(signed'(e_val)) - 33'(signed'(s_val));

  always_ff @(posedge clk) begin
    prod_r <= 51'(delta) * 51'(signed'({1'b0, factor}));
  end

  assign rnd = prod_r + 51'sd32768;
  assign res = s_val + rnd[47:16];

endmodule

/* rtl/core/keyframe_vector_interpolator_core.sv */
// Keyframe vector interpolator top level: key chain, scan control, divider, lerp.
// Sequencing: a load is written to its cell when taken; a query goes through the
// scan, pick, divide, multiply and sum states and then raises out_valid, skipping
// the divide when the factor clamps. One item at a time: in_stall is high from a
// taken query until its result leaves the output state, also while it is stalled.
// Reset: synchronous active-low rst_n clears control and sets key_count to 1;
// the key table has no reset and must be loaded before it is queried.
module keyframe_vector_interpolator_core #(
  parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [kvi_pkg::CNT_W-1:0]  cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_mode,
  input  logic [kvi_pkg::SLOT_W-1:0] in_key_slot,
  input  logic [31:0]                in_key_time,
  input  logic signed [31:0]         in_key_x,
  input  logic signed [31:0]         in_key_y,
  input  logic signed [31:0]         in_key_z,
  input  logic [31:0]                in_query_time,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [31:0]         out_x,
  output logic signed [31:0]         out_y,
  output logic signed [31:0]         out_z,
  output logic [kvi_pkg::SLOT_W-1:0] out_segment,
  output logic                       out_out_of_range
);

  localparam int IDX_W = $clog2(MAX_KEYS);
  localparam int NW    = $clog2(MAX_KEYS + 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SCAN = 7'b0000010,
    ST_PICK = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_SUM  = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [kvi_pkg::CNT_W-1:0] key_count_r;
  logic [NW-1:0] n_eff;

  always_comb begin
    if (key_count_r == '0) n_eff = NW'(1);
    else if (32'(key_count_r) > MAX_KEYS) n_eff = NW'(MAX_KEYS);
    else n_eff = NW'(key_count_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) key_count_r <= kvi_pkg::CNT_W'(1);
    else if (cfg_we) key_count_r <= cfg_wdata;
  end

  // Key chain: cells rotate toward cell 0 during a scan so cell 0/1 form the
  // current segment; a full rotation restores the original order.
  logic            in_acc;
  logic            shift_en;
  logic            load_we;
  kvi_pkg::key_t   load_key;
  kvi_pkg::key_t   keys [MAX_KEYS];

  assign in_acc   = in_valid && !in_stall;
  assign load_we  = in_acc && (in_mode == kvi_pkg::MODE_LOAD)
                    && (32'(in_key_slot) < MAX_KEYS);
  assign load_key = '{t: in_key_time, x: in_key_x, y: in_key_y, z: in_key_z};

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    kvi_cell #(.IDX_W(IDX_W), .MY_IDX(g)) u_cell (
      .clk      (clk),
      .load_we  (load_we),
      .load_idx (IDX_W'(in_key_slot)),
      .load_key (load_key),
      .shift_en (shift_en),
      .rot_sel  (1'b1),
      .next_key (keys[(g + 1) % MAX_KEYS]),
      .key_q    (keys[g])
    );
  end

  // Scan control.
  logic [IDX_W:0] step_r, step_nxt;
  logic [31:0] qt_r, qt_nxt;
  logic found_r, found_nxt;
  logic [IDX_W-1:0] seg_r, seg_nxt;
  kvi_pkg::key_t k0_r, k0_nxt, k1_r, k1_nxt;
  logic [kvi_pkg::FAC_W-1:0] fac_r, fac_nxt;
  logic flag_r, flag_nxt;
  logic single_r, single_nxt;
  logic div_start;
  logic div_done;
  logic [kvi_pkg::FAC_W-1:0] div_quo;
  logic [31:0] rx, ry, rz;
  logic [31:0] ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic [kvi_pkg::SLOT_W-1:0] oseg_r, oseg_nxt;
  logic oflag_r, oflag_nxt;

  assign shift_en = (state_r == ST_SCAN);
  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    qt_nxt     = qt_r;
    found_nxt  = found_r;
    seg_nxt    = seg_r;
    k0_nxt     = k0_r;
    k1_nxt     = k1_r;
    fac_nxt    = fac_r;
    flag_nxt   = flag_r;
    single_nxt = single_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    oz_nxt     = oz_r;
    oseg_nxt   = oseg_r;
    oflag_nxt  = oflag_r;
    div_start  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_mode == kvi_pkg::MODE_QUERY) begin
          qt_nxt     = in_query_time;
          step_nxt   = '0;
          found_nxt  = 1'b0;
          seg_nxt    = '0;
          k0_nxt     = keys[0];
          k1_nxt     = keys[1];
          single_nxt = (n_eff == NW'(1));
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // cell 0 holds key step, cell 1 holds key step+1 before this shift
        if (!found_r && (NW'(step_r) + NW'(1) < n_eff) && (qt_r < keys[1].t)) begin
          found_nxt = 1'b1;
          seg_nxt   = step_r[IDX_W-1:0];
          k0_nxt    = keys[0];
          k1_nxt    = keys[1];
        end
        step_nxt = step_r + (IDX_W+1)'(1);
        if (step_r == (IDX_W+1)'(MAX_KEYS - 1)) state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (single_r) begin
          fac_nxt  = '0;
          flag_nxt = 1'b0;
          k1_nxt   = k0_r;
          state_nxt = ST_MUL;
        end else if (qt_r <= k0_r.t) begin
          fac_nxt  = '0;
          flag_nxt = (qt_r < k0_r.t);
          state_nxt = ST_MUL;
        end else if (qt_r >= k1_r.t) begin
          fac_nxt  = kvi_pkg::FAC_W'(kvi_pkg::ONE_FACTOR);
          flag_nxt = (qt_r > k1_r.t);
          state_nxt = ST_MUL;
        end else begin
          flag_nxt  = 1'b0;
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          fac_nxt   = div_quo;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: state_nxt = ST_SUM;
      ST_SUM: begin
        ox_nxt    = rx;
        oy_nxt    = ry;
        oz_nxt    = rz;
        oseg_nxt  = kvi_pkg::SLOT_W'(seg_r);
        oflag_nxt = flag_r;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      found_r <= found_nxt;
    end
    qt_r     <= qt_nxt;
    seg_r    <= seg_nxt;
    k0_r     <= k0_nxt;
    k1_r     <= k1_nxt;
    fac_r    <= fac_nxt;
    flag_r   <= flag_nxt;
    single_r <= single_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    oz_r     <= oz_nxt;
    oseg_r   <= oseg_nxt;
    oflag_r  <= oflag_nxt;
  end

  kvi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (qt_r - k0_r.t),
    .den   (k1_r.t - k0_r.t),
    .done  (div_done),
    .quo   (div_quo)
  );

  kvi_lerp u_lx (.clk(clk), .s_val(k0_r.x), .e_val(k1_r.x), .factor(fac_r), .res(rx));
  kvi_lerp u_ly (.clk(clk), .s_val(k0_r.y), .e_val(k1_r.y), .factor(fac_r), .res(ry));
  kvi_lerp u_lz (.clk(clk), .s_val(k0_r.z), .e_val(k1_r.z), .factor(fac_r), .res(rz));

  assign out_x            = ox_r;
  assign out_y            = oy_r;
  assign out_z            = oz_r;
  assign out_segment      = oseg_r;
  assign out_out_of_range = oflag_r;

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_x))) else $error("result dropped");
  a_fac_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (fac_r <= kvi_pkg::FAC_W'(kvi_pkg::ONE_FACTOR)))
    else $error("factor above one");

endmodule
